/* hdl/lge_pkg.sv */
// Shared constants, types and row functions of the life generation engine.
package lge_pkg;

    localparam int GRID_SIZE = 256;
    localparam int ROW_W     = $clog2(GRID_SIZE);
    localparam int ADDR_W    = ROW_W + 1;
    localparam int DEPTH     = 2 * GRID_SIZE;
    localparam int CNT_W     = $clog2(GRID_SIZE * GRID_SIZE + 1);
    localparam int COORD_W   = 8;
    localparam int COUNT_W   = 17;
    localparam int COUNT_MAX = 131071;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef logic [GRID_SIZE-1:0] t_row;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             latch;
        logic             res_clr;
        logic             clr_we;
        logic             rd_en;
        logic             rd_cell;
        logic [ROW_W-1:0] row;
        logic             cell_wb;
        logic             cell_cap;
        logic             shift_rows;
        logic             row_wr;
        logic             cnt_clr;
        logic             cnt_shift;
        logic             res_step;
        logic             flip;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic in_grid;
    } t_status;

    // One generation of a whole row, from the rows above, at and below it.
    function automatic t_row next_row(input t_row up, input t_row mid, input t_row dn);
        t_row       res;
        logic [3:0] n;
        int         l;
        int         r;
        for (int c = 0; c < GRID_SIZE; c++) begin
            l = (c == 0) ? GRID_SIZE - 1 : c - 1;
            r = (c == GRID_SIZE - 1) ? 0 : c + 1;
            n = 4'(up[l]) + 4'(up[c]) + 4'(up[r]) + 4'(mid[l]) + 4'(mid[r])
              + 4'(dn[l]) + 4'(dn[c]) + 4'(dn[r]);
            res[c] = (n == 4'd3) || (mid[c] && (n == 4'd2));
        end
        return res;
    endfunction

    // A row word with one cell replaced.
    function automatic t_row set_cell(input t_row w, input logic [ROW_W-1:0] col,
                                      input logic v);
        t_row res;
        for (int c = 0; c < GRID_SIZE; c++) begin
            res[c] = (col == ROW_W'(c)) ? v : w[c];
        end
        return res;
    endfunction

endpackage

/* hdl/lge_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lge_datapath.sv */
// Datapath of the life generation engine: grid RAM, row window, counter, results.
module lge_datapath import lge_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [1:0]          i_op,
    input  logic [COORD_W-1:0]  i_row,
    input  logic [COORD_W-1:0]  i_column,
    input  logic                i_cell_in,
    output t_status             o_status,
    output logic                o_cell_out,
    output logic [COUNT_W-1:0]  o_live_count
);

    logic               r_bank;
    t_op                r_op;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic               r_val;
    t_row               r_up, r_mid, r_dn, r_shreg;
    logic [CNT_W-1:0]   r_count;
    logic               r_cell_out;
    logic [COUNT_W-1:0] r_live;

    logic               we, re;
    logic [ADDR_W-1:0]  waddr, raddr;
    t_row               wdata, rdata;
    logic [ROW_W-1:0]   cell_row, cell_col;

    assign cell_row = ROW_W'(r_row);
    assign cell_col = ROW_W'(r_col);

    always_comb begin
        we    = i_cmd.clr_we | i_cmd.cell_wb | i_cmd.row_wr;
        waddr = {1'b0, i_cmd.row};
        wdata = '0;
        if (i_cmd.cell_wb) begin
            waddr = {r_bank, cell_row};
            wdata = set_cell(rdata, cell_col, r_val);
        end else if (i_cmd.row_wr) begin
            waddr = {~r_bank, i_cmd.row};
            wdata = next_row(r_up, r_mid, r_dn);
        end
        re    = i_cmd.rd_en;
        raddr = {r_bank, i_cmd.rd_cell ? cell_row : i_cmd.row};
    end

    lge_ram #(.WIDTH(GRID_SIZE), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
        end else if (i_cmd.flip) begin
            r_bank <= ~r_bank;
        end
        if (i_cmd.latch) begin
            r_op  <= t_op'(i_op);
            r_row <= i_row;
            r_col <= i_column;
            r_val <= i_cell_in;
        end
        if (i_cmd.shift_rows) begin
            r_up  <= r_mid;
            r_mid <= r_dn;
            r_dn  <= rdata;
        end
        if (i_cmd.row_wr) begin
            r_shreg <= next_row(r_up, r_mid, r_dn);
        end else if (i_cmd.cnt_shift) begin
            r_shreg <= r_shreg >> 1;
        end
        if (i_cmd.cnt_clr) begin
            r_count <= '0;
        end else if (i_cmd.cnt_shift) begin
            r_count <= r_count + CNT_W'(r_shreg[0]);
        end
        if (i_cmd.res_clr) begin
            r_cell_out <= 1'b0;
            r_live     <= '0;
        end else begin
            if (i_cmd.cell_cap) begin
                r_cell_out <= rdata[cell_col];
            end
            if (i_cmd.res_step) begin
                r_live <= (32'(r_count) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                     : COUNT_W'(r_count);
            end
        end
    end

    assign o_status.op      = r_op;
    assign o_status.in_grid = (32'(r_row) < GRID_SIZE) && (32'(r_col) < GRID_SIZE);
    assign o_cell_out       = r_cell_out;
    assign o_live_count     = r_live;

endmodule

/* hdl/lge_ctrl.sv */
// Controller state machine of the life generation engine.
module lge_ctrl import lge_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_done
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_CELL,
        S_FETCH,
        S_ROW,
        S_COUNT,
        S_FINISH,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_out, n_out;
    logic [ROW_W-1:0] r_rd, n_rd;
    logic [ROW_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_f, n_f;

    localparam logic [ROW_W-1:0] LAST = ROW_W'(GRID_SIZE - 1);

    function automatic logic [ROW_W-1:0] wrap_inc(input logic [ROW_W-1:0] v);
        return (v == LAST) ? '0 : v + 1'b1;
    endfunction

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_rd    = r_rd;
        n_cnt   = r_cnt;
        n_f     = r_f;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                o_cmd.row    = r_out;
                n_out        = wrap_inc(r_out);
                if (r_out == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.res_clr = 1'b1;
                n_state       = S_DONE;
                if (i_status.op == OP_STEP) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_rd          = LAST;
                    n_out         = '0;
                    n_f           = '0;
                    n_state       = S_FETCH;
                end else if ((i_status.op == OP_WRITE || i_status.op == OP_READ)
                             && i_status.in_grid) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_cell = 1'b1;
                    n_state       = S_CELL;
                end
            end
            S_CELL: begin
                o_cmd.cell_wb  = (i_status.op == OP_WRITE);
                o_cmd.cell_cap = (i_status.op == OP_READ);
                n_state        = S_DONE;
            end
            S_FETCH: begin
                o_cmd.rd_en      = (r_f != 2'd3);
                o_cmd.row        = r_rd;
                o_cmd.shift_rows = (r_f != 2'd0);
                n_f              = r_f + 2'd1;
                if (r_f != 2'd3) begin
                    n_rd = wrap_inc(r_rd);
                end else begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.row_wr = 1'b1;
                o_cmd.row    = r_out;
                n_cnt        = '0;
                n_state      = S_COUNT;
            end
            S_COUNT: begin
                // The row two below the output row is read in the first count
                // cycle and enters the window in the second.
                o_cmd.rd_en      = (r_cnt == '0);
                o_cmd.row        = r_rd;
                o_cmd.shift_rows = (r_cnt == ROW_W'(1));
                o_cmd.cnt_shift  = 1'b1;
                n_cnt            = r_cnt + 1'b1;
                if (r_cnt == '0) begin
                    n_rd = wrap_inc(r_rd);
                end
                if (r_cnt == LAST) begin
                    n_out   = wrap_inc(r_out);
                    n_state = (r_out == LAST) ? S_FINISH : S_ROW;
                end
            end
            S_FINISH: begin
                o_cmd.res_step = 1'b1;
                o_cmd.flip     = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_out   <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
            r_f     <= '0;
        end else begin
            r_state <= n_state;
            r_out   <= n_out;
            r_rd    <= n_rd;
            r_cnt   <= n_cnt;
            r_f     <= n_f;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

/* hdl/life_generation_engine_core.sv */
// Top level of the life generation engine: controller and datapath.
//
// A square toroidal grid of GRID_SIZE by GRID_SIZE one-bit cells (B3/S23 rules).
// A command transaction is accepted on a rising edge with start high and busy
// low; i_op selects write cell, read cell or compute one generation, with
// i_row, i_column and i_cell_in for the cell operations.
// Each transaction returns exactly one result: o_done is high for one cycle
// with o_cell_out (read value) and o_live_count (live cells after a step).
// The receiver cannot stall; results must be taken when o_done is high.
// A cell write or read goes from dispatch through a cell access state to the
// result, an unused op code from dispatch straight to it. For a generation
// the grid is kept one row per RAM word, a whole row of new cells is formed
// at once, and the live count is gathered one cell per cycle from a shift
// register.
// Busy drops in the cycle after o_done, so one transaction follows another.
// The two grid buffers share one RAM; a bank bit chooses the current one.
// After reset a clearing pass writes GRID_SIZE zero rows, one per cycle,
// into the current bank while busy stays high.
module life_generation_engine_core import lge_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_column,
    input  logic               i_cell_in,
    output logic               o_done,
    output logic               o_cell_out,
    output logic [COUNT_W-1:0] o_live_count
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences clearing, cell access and the row sweep.
    lge_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // The datapath holds the grid, the three-row window and the results.
    lge_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_op),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_cell_in    (i_cell_in),
        .o_status     (status),
        .o_cell_out   (o_cell_out),
        .o_live_count (o_live_count)
    );

endmodule

/* hdl/lge_checker.sv */
// Port-level checker of the life generation engine, bound to the top level.
module lge_checker import lge_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic               o_cell_out,
    input logic [COUNT_W-1:0] o_live_count
);

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result shown while idle");

    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("not idle after result");

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_cell_out) |-> (o_live_count == '0))
        else $error("read result carries a live count");

endmodule

bind life_generation_engine_core lge_checker u_lge_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_cell_out   (o_cell_out),
    .o_live_count (o_live_count)
);

/* tb/life_generation_engine_core_tb.sv */
// Testbench for the life generation engine: directed patterns, random commands, scoreboard.
`timescale 1ns / 1ps

module life_generation_engine_core_tb;
    import lge_pkg::*;

    localparam int CELLS = GRID_SIZE * GRID_SIZE;

    // One expected result of a command transaction.
    typedef struct {
        logic               cell_val;
        logic [COUNT_W-1:0] count;
    } t_expect;

    // The scoreboard keeps its own copy of both grid buffers and the bank bit,
    // so it can work out the result of every accepted transaction.
    class life_scoreboard;
        bit      grid [2][CELLS];
        bit      bank;
        t_expect awaited [$];
        int      errors;

        function void clear();
            foreach (grid[b, i]) grid[b][i] = 1'b0;
            bank = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // One B3/S23 generation with wrap at every edge; returns the live count.
        function int generation();
            int up, dn, lf, rt, n, live;
            bit nv;
            live = 0;
            for (int r = 0; r < GRID_SIZE; r++) begin
                up = (r == 0) ? GRID_SIZE - 1 : r - 1;
                dn = (r == GRID_SIZE - 1) ? 0 : r + 1;
                for (int c = 0; c < GRID_SIZE; c++) begin
                    lf = (c == 0) ? GRID_SIZE - 1 : c - 1;
                    rt = (c == GRID_SIZE - 1) ? 0 : c + 1;
                    n = grid[bank][up*GRID_SIZE+lf] + grid[bank][up*GRID_SIZE+c]
                      + grid[bank][up*GRID_SIZE+rt] + grid[bank][r*GRID_SIZE+lf]
                      + grid[bank][r*GRID_SIZE+rt] + grid[bank][dn*GRID_SIZE+lf]
                      + grid[bank][dn*GRID_SIZE+c] + grid[bank][dn*GRID_SIZE+rt];
                    nv = (n == 3) || (grid[bank][r*GRID_SIZE+c] && n == 2);
                    grid[!bank][r*GRID_SIZE+c] = nv;
                    live += nv;
                end
            end
            bank = !bank;
            return live;
        endfunction

        // Notes an accepted command and queues the result it must produce.
        function void note(t_op op, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                           logic val);
            t_expect e;
            int live;
            e.cell_val = 1'b0;
            e.count    = '0;
            case (op)
                OP_WRITE: grid[bank][row*GRID_SIZE+col] = val;
                OP_READ:  e.cell_val = grid[bank][row*GRID_SIZE+col];
                OP_STEP: begin
                    live = generation();
                    e.count = COUNT_W'((live > COUNT_MAX) ? COUNT_MAX : live);
                end
                default: ;
            endcase
            awaited.push_back(e);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compares one result with the oldest expectation, field by field.
        task check(logic cell_val, logic [COUNT_W-1:0] count);
            t_expect e;
            if (awaited.size() == 0) begin
                report("result with no transaction outstanding");
            end else begin
                e = awaited.pop_front();
                if (cell_val !== e.cell_val)
                    report($sformatf("cell_out %b, expected %b", cell_val, e.cell_val));
                if (count !== e.count)
                    report($sformatf("live_count %0d, expected %0d", count, e.count));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_op;
    logic [COORD_W-1:0] i_row;
    logic [COORD_W-1:0] i_column;
    logic               i_cell_in;
    logic               o_done;
    logic               o_cell_out;
    logic [COUNT_W-1:0] o_live_count;

    life_scoreboard sb;
    int             steps_left;

    life_generation_engine_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_cell_in    (i_cell_in),
        .o_done       (o_done),
        .o_cell_out   (o_cell_out),
        .o_live_count (o_live_count)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Results cannot be held off, so every strobe is checked at the edge
    // that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check(o_cell_out, o_live_count);
        end
    end

    // Most idle gaps are short, a few are long, and about a third are none.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 35) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Drives one command transaction and returns once it has been accepted.
    // The inputs change at the next falling edge after the gap, so they never
    // collide with the lowering of start by the previous transaction.
    // Start is lowered at the following falling edge; busy is high by then,
    // so no second transaction can slip in.
    task automatic send(t_op op, int row, int col, bit val, int gap);
        repeat (gap + 1) @(negedge i_clk);
        i_op      <= op;
        i_row     <= COORD_W'(row);
        i_column  <= COORD_W'(col);
        i_cell_in <= val;
        start     <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note(op, COORD_W'(row), COORD_W'(col), val);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic put(int row, int col, bit val);
        send(OP_WRITE, row, col, val, pick_gap());
    endtask

    // Waits until every outstanding result has been seen.
    task automatic drain();
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // A random mostly well-formed sequence: a small pattern is written around a
    // random anchor, often at the grid border so the wrap gets exercised, then
    // up to three generations run, mixed with reads of the neighborhood and noise.
    task automatic random_burst();
        int base_r, base_c, n, p;
        base_r = ($urandom_range(0, 2) == 0) ? $urandom_range(252, 255) : $urandom_range(0, 255);
        base_c = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
        n = $urandom_range(3, 9);
        for (int k = 0; k < n; k++) begin
            put((base_r + $urandom_range(0, 3)) % GRID_SIZE,
                (base_c + $urandom_range(0, 3)) % GRID_SIZE, $urandom_range(0, 4) != 0);
        end
        for (int k = 0; k < 3; k++) begin
            p = $urandom_range(0, 9);
            if (p < 4 && steps_left > 0) begin
                steps_left--;
                send(OP_STEP, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 1), pick_gap());
            end else if (p < 8) begin
                send(OP_READ, (base_r + $urandom_range(0, 4)) % GRID_SIZE,
                     (base_c + $urandom_range(0, 4)) % GRID_SIZE, $urandom_range(0, 1),
                     pick_gap());
            end else begin
                // Noise: unused op code or a cell anywhere on the grid.
                send(($urandom_range(0, 1) != 0) ? OP_NONE : OP_READ,
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                     pick_gap());
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        start     = 1'b0;
        i_op      = OP_NONE;
        i_row     = '0;
        i_column  = '0;
        i_cell_in = 1'b0;
        i_rst_n   = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A glider straddles the bottom-right corner so that
        // its neighbor counts wrap across both edges at once.
        send(OP_READ, 255, 255, 1'b1, 0);
        send(OP_READ, 0, 0, 1'b0, 0);
        put(254, 0, 1'b1);
        put(255, 1, 1'b1);
        put(0, 255, 1'b1);
        put(0, 0, 1'b1);
        put(0, 1, 1'b1);
        // A vertical blinker at the left edge, with a cell written then killed.
        put(100, 0, 1'b1);
        put(101, 0, 1'b1);
        put(102, 0, 1'b1);
        put(170, 85, 1'b1);
        put(170, 85, 1'b0);
        send(OP_NONE, 255, 255, 1'b1, 0);
        send(OP_READ, 0, 255, 1'b0, 1);
        send(OP_STEP, 255, 255, 1'b1, 0);
        send(OP_READ, 101, 255, 1'b1, 0);
        send(OP_READ, 101, 1, 1'b0, 0);
        send(OP_STEP, 0, 0, 1'b0, 2);
        send(OP_READ, 170, 85, 1'b1, 0);
        // Hold off until the pipeline is empty before the next command.
        drain();
        send(OP_STEP, 85, 170, 1'b0, 0);
        send(OP_READ, 0, 0, 1'b0, 0);

        // Random part.
        steps_left = 14;
        for (int k = 0; k < 10; k++) begin
            random_burst();
            if (k == 5) drain();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: the timeout leaves room for all generations of the test several times over.
    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hdl/lge_pkg.sv
hdl/lge_ram.sv
hdl/lge_datapath.sv
hdl/lge_ctrl.sv
hdl/life_generation_engine_core.sv
hdl/lge_checker.sv
tb/life_generation_engine_core_tb.sv
